// ----- rtl/core/swcc_pkg.sv -----
// ----------------------------------------------------------------------------
// swcc_pkg
// shared types and constants for the stick weighted cross correlation block
// ----------------------------------------------------------------------------
package swcc_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 32;
    localparam int INT_W   = 16;
    localparam int STICK_W = POS_W + INT_W;
    localparam int WIDTH_W = 20;
    localparam int PROD_W  = 2 * INT_W;
    localparam int TERM_W  = PROD_W + WIDTH_W;
    localparam int ACC_W   = 64;
    localparam int RES_W   = 63;

    localparam int DIV_STEPS   = ACC_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int ROOT_STEPS  = ACC_W / 2;
    localparam int ROOT_CNT_W  = $clog2(ROOT_STEPS);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(65536);

    localparam logic [CMD_W-1:0] CMD_CLEAR         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CROSS         = 3'd3;
    localparam logic [CMD_W-1:0] CMD_AUTO          = 3'd4;

    typedef struct packed {
        logic clear;
        logic append_first;
        logic append_second;
        logic start;
        logic auto_mode;
        logic issue;
        logic div_load;
        logic div_step;
        logic root_load;
        logic root_step;
        logic out_load;
    } swcc_ctrl_t;

    typedef struct packed {
        logic no_pairs;
        logic last_pair;
        logic pipe_busy;
        logic div_last;
        logic root_last;
        logic auto_mode;
    } swcc_stat_t;

endpackage

// ----- rtl/core/stick_weighted_cross_correlation.sv -----
// ----------------------------------------------------------------------------
// stick_weighted_cross_correlation
// triangle kernel weighted correlation of two stick lists
// ----------------------------------------------------------------------------
// clear and append beats: accepted one per cycle, no result
// cross compute: result follows the beat (walk, drain, divide)
// auto compute: result follows the beat (walk, drain, 64 step divide, 32 step root)
// pair walk runs one pair per cycle, reading list one at i and j and list two at j
// no new beat is taken during a compute; a waiting result holds the next handoff
// reset: lists empty, overflow clear, triangle width 1.0, no result pending
module stick_weighted_cross_correlation #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [swcc_pkg::WIDTH_W-1:0]       cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [swcc_pkg::CMD_W-1:0]         s_command,
    input  logic [swcc_pkg::POS_W-1:0]         s_position,
    input  logic [swcc_pkg::INT_W-1:0]         s_intensity,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [swcc_pkg::RES_W-1:0]         m_result_value,
    output logic                               m_list_overflow,
    output logic                               m_saturated
);

    swcc_pkg::swcc_ctrl_t ctrl;
    swcc_pkg::swcc_stat_t stat;

    swcc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    swcc_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_position    (s_position),
        .s_intensity   (s_intensity),
        .ctrl          (ctrl),
        .stat          (stat),
        .result_value  (m_result_value),
        .list_overflow (m_list_overflow),
        .saturated     (m_saturated)
    );

endmodule

// ----- rtl/core/swcc_dp.sv -----
// ----------------------------------------------------------------------------
// swcc_dp
// stick lists, pair walk pipeline, saturating accumulator, divider and root
// ----------------------------------------------------------------------------
module swcc_dp #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [swcc_pkg::WIDTH_W-1:0]       cfg_wr_data,
    input  logic [swcc_pkg::POS_W-1:0]         s_position,
    input  logic [swcc_pkg::INT_W-1:0]         s_intensity,
    input  swcc_pkg::swcc_ctrl_t               ctrl,
    output swcc_pkg::swcc_stat_t               stat,
    output logic [swcc_pkg::RES_W-1:0]         result_value,
    output logic                               list_overflow,
    output logic                               saturated
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
    localparam int POS_LO = swcc_pkg::INT_W;
    localparam int POS_HI = swcc_pkg::STICK_W - 1;

    // configuration
    logic [swcc_pkg::WIDTH_W-1:0] width_reg;

    // lists
    logic [swcc_pkg::STICK_W-1:0] mem1 [LIST_DEPTH];
    logic [swcc_pkg::STICK_W-1:0] mem2 [LIST_DEPTH];
    logic [CNT_W-1:0]             count1_reg;
    logic [CNT_W-1:0]             count2_reg;
    logic                         ovf_reg;
    logic                         auto_reg;

    // pair walk
    logic [IDX_W-1:0]             i_reg;
    logic [IDX_W-1:0]             j_reg;
    logic [CNT_W-1:0]             na;
    logic [CNT_W-1:0]             nb;
    logic                         i_last;
    logic                         j_last;
    logic [swcc_pkg::STICK_W-1:0] rd_a_reg;
    logic [swcc_pkg::STICK_W-1:0] rd_b1_reg;
    logic [swcc_pkg::STICK_W-1:0] rd_b2_reg;
    logic [swcc_pkg::STICK_W-1:0] rd_b;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         v3_reg;
    logic [swcc_pkg::POS_W-1:0]   pos_a;
    logic [swcc_pkg::POS_W-1:0]   pos_b;
    logic [swcc_pkg::POS_W-1:0]   pair_dist;
    logic                         hit;
    logic [swcc_pkg::PROD_W-1:0]  prod_reg;
    logic [swcc_pkg::WIDTH_W-1:0] wd_reg;
    logic [swcc_pkg::TERM_W-1:0]  term_reg;
    logic [swcc_pkg::ACC_W:0]     acc_sum;
    logic [swcc_pkg::ACC_W-1:0]   acc_reg;
    logic                         sat_reg;

    // divider
    logic [swcc_pkg::ACC_W-1:0]     dvd_reg;
    logic [swcc_pkg::WIDTH_W-1:0]   rem_reg;
    logic [swcc_pkg::WIDTH_W:0]     rem_sh;
    logic                           rem_ge;
    logic [swcc_pkg::WIDTH_W-1:0]   rem_next;
    logic [swcc_pkg::DIV_CNT_W-1:0] dcnt_reg;
    logic [swcc_pkg::ACC_W-1:0]     quot;

    // square root
    logic [swcc_pkg::ACC_W-1:0]      rv_reg;
    logic [swcc_pkg::ACC_W-1:0]      root_reg;
    logic [swcc_pkg::ACC_W-1:0]      bit_reg;
    logic [swcc_pkg::ACC_W-1:0]      root_try;
    logic                            root_ge;
    logic [swcc_pkg::ROOT_CNT_W-1:0] rcnt_reg;

    // result
    logic [swcc_pkg::RES_W-1:0] result_reg;
    logic                       ovf_out_reg;
    logic                       sat_out_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= swcc_pkg::WIDTH_RESET;
        end else if (cfg_wr_en) begin
            width_reg <= cfg_wr_data;
        end
    end

    // list memories
    always_ff @(posedge aclk) begin
        if (ctrl.append_first && count1_reg != DEPTH_C) begin
            mem1[count1_reg[IDX_W-1:0]] <= {s_position, s_intensity};
        end
        if (ctrl.append_second && count2_reg != DEPTH_C) begin
            mem2[count2_reg[IDX_W-1:0]] <= {s_position, s_intensity};
        end
        rd_a_reg  <= mem1[i_reg];
        rd_b1_reg <= mem1[j_reg];
        rd_b2_reg <= mem2[j_reg];
    end

    // list bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count1_reg <= '0;
            count2_reg <= '0;
            ovf_reg    <= 1'b0;
        end else if (ctrl.clear) begin
            count1_reg <= '0;
            count2_reg <= '0;
            ovf_reg    <= 1'b0;
        end else if (ctrl.append_first) begin
            if (count1_reg != DEPTH_C) begin
                count1_reg <= count1_reg + CNT_W'(1);
            end else begin
                ovf_reg <= 1'b1;
            end
        end else if (ctrl.append_second) begin
            if (count2_reg != DEPTH_C) begin
                count2_reg <= count2_reg + CNT_W'(1);
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // pair indices
    assign na     = count1_reg;
    assign nb     = auto_reg ? count1_reg : count2_reg;
    assign i_last = (CNT_W'(i_reg) == na - CNT_W'(1));
    assign j_last = (CNT_W'(j_reg) == nb - CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
        end else if (ctrl.start) begin
            auto_reg <= ctrl.auto_mode;
            i_reg    <= '0;
            j_reg    <= '0;
        end else if (ctrl.issue) begin
            if (j_last) begin
                j_reg <= '0;
                i_reg <= i_reg + IDX_W'(1);
            end else begin
                j_reg <= j_reg + IDX_W'(1);
            end
        end
    end

    // distance and kernel test
    assign rd_b      = auto_reg ? rd_b1_reg : rd_b2_reg;
    assign pos_a     = rd_a_reg[POS_HI:POS_LO];
    assign pos_b     = rd_b[POS_HI:POS_LO];
    assign pair_dist = (pos_a >= pos_b) ? (pos_a - pos_b) : (pos_b - pos_a);
    assign hit       = (pair_dist < swcc_pkg::POS_W'(width_reg));

    always_ff @(posedge aclk) begin
        prod_reg <= swcc_pkg::PROD_W'(rd_a_reg[swcc_pkg::INT_W-1:0])
                  * swcc_pkg::PROD_W'(rd_b[swcc_pkg::INT_W-1:0]);
        wd_reg   <= width_reg - pair_dist[swcc_pkg::WIDTH_W-1:0];
        term_reg <= swcc_pkg::TERM_W'(prod_reg) * swcc_pkg::TERM_W'(wd_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg && hit;
            v3_reg <= v2_reg;
        end
    end

    // saturating accumulator
    assign acc_sum = {1'b0, acc_reg} + (swcc_pkg::ACC_W + 1)'(term_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (ctrl.start) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (v3_reg) begin
            if (acc_sum[swcc_pkg::ACC_W]) begin
                acc_reg <= '1;
                sat_reg <= 1'b1;
            end else begin
                acc_reg <= acc_sum[swcc_pkg::ACC_W-1:0];
            end
        end
    end

    // restoring divider, one quotient bit per beat of the counter
    assign rem_sh   = {rem_reg, dvd_reg[swcc_pkg::ACC_W-1]};
    assign rem_ge   = (rem_sh >= (swcc_pkg::WIDTH_W + 1)'(width_reg));
    assign rem_next = rem_ge ? swcc_pkg::WIDTH_W'(rem_sh - (swcc_pkg::WIDTH_W + 1)'(width_reg))
                             : rem_sh[swcc_pkg::WIDTH_W-1:0];
    assign quot     = (width_reg == '0) ? '0 : dvd_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.div_load) begin
            dvd_reg  <= acc_reg;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (ctrl.div_step) begin
            dvd_reg  <= {dvd_reg[swcc_pkg::ACC_W-2:0], rem_ge};
            rem_reg  <= rem_next;
            dcnt_reg <= dcnt_reg + swcc_pkg::DIV_CNT_W'(1);
        end
    end

    // bit-pair integer square root
    assign root_try = root_reg + bit_reg;
    assign root_ge  = (rv_reg >= root_try);

    always_ff @(posedge aclk) begin
        if (ctrl.root_load) begin
            rv_reg   <= quot;
            root_reg <= '0;
            bit_reg  <= swcc_pkg::ACC_W'(1) << (swcc_pkg::ACC_W - 2);
            rcnt_reg <= '0;
        end else if (ctrl.root_step) begin
            if (root_ge) begin
                rv_reg   <= rv_reg - root_try;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            rcnt_reg <= rcnt_reg + swcc_pkg::ROOT_CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            ovf_out_reg <= ovf_reg;
            if (auto_reg) begin
                result_reg  <= root_reg[swcc_pkg::RES_W-1:0];
                sat_out_reg <= sat_reg;
            end else if (quot[swcc_pkg::ACC_W-1]) begin
                result_reg  <= '1;
                sat_out_reg <= 1'b1;
            end else begin
                result_reg  <= quot[swcc_pkg::RES_W-1:0];
                sat_out_reg <= sat_reg;
            end
        end
    end

    assign result_value  = result_reg;
    assign list_overflow = ovf_out_reg;
    assign saturated     = sat_out_reg;

    assign stat.no_pairs  = (na == '0) || (nb == '0);
    assign stat.last_pair = i_last && j_last;
    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign stat.div_last  = (dcnt_reg == '1);
    assign stat.root_last = (rcnt_reg == '1);
    assign stat.auto_mode = auto_reg;

    a_count1_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count1_reg <= DEPTH_C)
        else $error("list one count beyond depth");

    a_count2_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count2_reg <= DEPTH_C)
        else $error("list two count beyond depth");

    a_acc_sat_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (sat_reg && !ctrl.start) |=> sat_reg)
        else $error("saturation flag lost during walk");

endmodule

// ----- rtl/core/swcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// swcc_ctrl
// command decode and sequencing of walk, divide, root and result handoff
// ----------------------------------------------------------------------------
module swcc_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic [swcc_pkg::CMD_W-1:0]   s_command,
    output logic                         s_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    input  swcc_pkg::swcc_stat_t         stat,
    output swcc_pkg::swcc_ctrl_t         ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DIV,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        ctrl         = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        swcc_pkg::CMD_CLEAR:         ctrl.clear = 1'b1;
                        swcc_pkg::CMD_APPEND_FIRST:  ctrl.append_first = 1'b1;
                        swcc_pkg::CMD_APPEND_SECOND: ctrl.append_second = 1'b1;
                        swcc_pkg::CMD_CROSS: begin
                            ctrl.start = 1'b1;
                            state_next = ST_WALK;
                        end
                        swcc_pkg::CMD_AUTO: begin
                            ctrl.start     = 1'b1;
                            ctrl.auto_mode = 1'b1;
                            state_next     = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (stat.no_pairs) begin
                    state_next = ST_DRAIN;
                end else begin
                    ctrl.issue = 1'b1;
                    if (stat.last_pair) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    ctrl.div_load = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                ctrl.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = stat.auto_mode ? ST_ROOT_INIT : ST_DONE;
                end
            end
            ST_ROOT_INIT: begin
                ctrl.root_load = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT: begin
                ctrl.root_step = 1'b1;
                if (stat.root_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    ctrl.out_load = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_no_issue_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && stat.no_pairs) |-> !ctrl.issue)
        else $error("pair issued with an empty list");

    a_drain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && stat.pipe_busy) |=> (state_reg == ST_DRAIN))
        else $error("divide started before the walk pipeline emptied");

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the stick weighted cross correlation block against a behavioral
// predictor of the two stick lists, the triangle-weighted pair walk, the
// final division and the auto-mode square root. A directed part covers
// empty lists, extreme positions and intensities, unused commands and a zero
// width. It is followed by random phases at several triangle widths. Each
// phase mixes clustered appends, full lists, clears and noise. The sender
// works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CMD_W   = swcc_pkg::CMD_W;
    localparam int POS_W   = swcc_pkg::POS_W;
    localparam int INT_W   = swcc_pkg::INT_W;
    localparam int WIDTH_W = swcc_pkg::WIDTH_W;
    localparam int ACC_W   = swcc_pkg::ACC_W;
    localparam int RES_W   = swcc_pkg::RES_W;

    localparam int LIST_DEPTH     = 32;
    localparam int SETTLE_CYCLES  = LIST_DEPTH * LIST_DEPTH + 128;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_BEATS    = 120;

    localparam bit [RES_W-1:0] RESULT_MAX = '1;
    localparam bit [ACC_W-1:0] ACC_MAX    = '1;

    typedef struct packed {
        bit [POS_W-1:0] pos;
        bit [INT_W-1:0] inten;
    } stick_t;

    typedef struct {
        bit [RES_W-1:0] value;
        bit             overflow;
        bit             saturated;
    } corr_result_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [WIDTH_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [CMD_W-1:0]   s_command;
    logic [POS_W-1:0]   s_position;
    logic [INT_W-1:0]   s_intensity;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [RES_W-1:0]   m_result_value;
    logic               m_list_overflow;
    logic               m_saturated;

    stick_t             first_list [LIST_DEPTH];
    stick_t             second_list [LIST_DEPTH];
    int                 first_count = 0;
    int                 second_count = 0;
    bit                 overflow_flag = 1'b0;
    bit [WIDTH_W-1:0]   tri_width = swcc_pkg::WIDTH_RESET;

    corr_result_t       pending_results [$];
    int                 mismatch_count = 0;
    int                 command_beats = 0;
    int                 burst_left = 0;
    int                 ready_cycle = 0;
    int                 idle_cycles = 0;

    stick_weighted_cross_correlation #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_position(s_position),
        .s_intensity(s_intensity),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_value(m_result_value),
        .m_list_overflow(m_list_overflow),
        .m_saturated(m_saturated)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit [ACC_W-1:0] int_sqrt(input bit [ACC_W-1:0] v);
        bit [ACC_W-1:0] lo;
        bit [ACC_W-1:0] hi;
        bit [ACC_W-1:0] mid;
        lo = '0;
        hi = 64'h1_0000_0000;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic corr_result_t correlate(input bit auto_mode);
        bit [ACC_W-1:0] acc;
        bit [ACC_W-1:0] term;
        bit [ACC_W-1:0] quotient;
        bit [POS_W-1:0] pair_dist;
        stick_t         a;
        stick_t         b;
        bit             sat;
        int             n_b;
        int             i;
        int             j;
        corr_result_t   r;
        acc = '0;
        sat = 1'b0;
        n_b = auto_mode ? first_count : second_count;
        for (i = 0; i < first_count; i++) begin
            for (j = 0; j < n_b; j++) begin
                a = first_list[i];
                b = auto_mode ? first_list[j] : second_list[j];
                pair_dist = (a.pos >= b.pos) ? a.pos - b.pos : b.pos - a.pos;
                if (pair_dist < POS_W'(tri_width)) begin
                    term = ACC_W'(a.inten) * ACC_W'(b.inten)
                         * (ACC_W'(tri_width) - ACC_W'(pair_dist));
                    if (acc > ACC_MAX - term) begin
                        acc = ACC_MAX;
                        sat = 1'b1;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        quotient = (tri_width != 0) ? acc / ACC_W'(tri_width) : '0;
        if (auto_mode) begin
            r.value = RES_W'(int_sqrt(quotient));
        end else if (quotient > ACC_W'(RESULT_MAX)) begin
            r.value = RESULT_MAX;
            sat = 1'b1;
        end else begin
            r.value = quotient[RES_W-1:0];
        end
        r.overflow = overflow_flag;
        r.saturated = sat;
        return r;
    endfunction

    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic [INT_W-1:0] inten);
        case (cmd)
            swcc_pkg::CMD_CLEAR: begin
                first_count = 0;
                second_count = 0;
                overflow_flag = 1'b0;
            end
            swcc_pkg::CMD_APPEND_FIRST: begin
                if (first_count < LIST_DEPTH) begin
                    first_list[first_count] = '{pos: pos, inten: inten};
                    first_count++;
                end else begin
                    overflow_flag = 1'b1;
                end
            end
            swcc_pkg::CMD_APPEND_SECOND: begin
                if (second_count < LIST_DEPTH) begin
                    second_list[second_count] = '{pos: pos, inten: inten};
                    second_count++;
                end else begin
                    overflow_flag = 1'b1;
                end
            end
            swcc_pkg::CMD_CROSS: pending_results.push_back(correlate(1'b0));
            swcc_pkg::CMD_AUTO: pending_results.push_back(correlate(1'b1));
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [INT_W-1:0] inten);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                s_command <= CMD_W'($urandom);
                s_position <= $urandom;
                s_intensity <= INT_W'($urandom);
                repeat (gap) @(posedge aclk);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_position <= pos;
        s_intensity <= inten;
        do @(posedge aclk); while (s_ready !== 1'b1);
        apply_command(cmd, pos, inten);
        burst_left--;
        if (cmd <= swcc_pkg::CMD_AUTO) begin
            command_beats++;
        end
    endtask

    task automatic wait_for_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_triangle_width(input logic [WIDTH_W-1:0] w);
        wait_for_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tri_width = w;
    endtask

    // optional unused command and clear, appends clustered around one base, then one to three computes
    task automatic run_sequence(input bit force_full);
        int             n_first;
        int             n_second;
        int             span;
        int             offset;
        bit [POS_W-1:0] base;
        bit [POS_W-1:0] pos;
        bit [POS_W-1:0] prev_pos;
        bit [INT_W-1:0] inten;
        bit             to_first;
        if ($urandom_range(0, 7) == 0) begin
            send_beat(CMD_W'($urandom_range(5, 7)), $urandom, INT_W'($urandom));
        end
        if (force_full || $urandom_range(0, 4) != 0) begin
            send_beat(swcc_pkg::CMD_CLEAR, $urandom, INT_W'($urandom));
        end
        n_first = force_full ? $urandom_range(33, 36)
                : ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
        n_second = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
        case ($urandom_range(0, 5))
            0: base = '0;
            1: base = '1;
            default: base = $urandom;
        endcase
        span = (tri_width == 0) ? 64 : 2 * int'(tri_width) + 16;
        prev_pos = base;
        while (n_first + n_second > 0) begin
            to_first = (n_second == 0) || (n_first != 0 && $urandom_range(0, 1) == 1);
            case ($urandom_range(0, 7))
                0: pos = $urandom;
                1, 2: pos = prev_pos;
                default: begin
                    offset = int'($urandom_range(0, 2 * span)) - span;
                    pos = base + POS_W'(offset);
                end
            endcase
            case ($urandom_range(0, 5))
                0: inten = '0;
                1: inten = '1;
                default: inten = INT_W'($urandom);
            endcase
            prev_pos = pos;
            if (to_first) begin
                send_beat(swcc_pkg::CMD_APPEND_FIRST, pos, inten);
                n_first--;
            end else begin
                send_beat(swcc_pkg::CMD_APPEND_SECOND, pos, inten);
                n_second--;
            end
        end
        repeat ($urandom_range(1, 3)) begin
            send_beat(($urandom_range(0, 1) == 1) ? swcc_pkg::CMD_CROSS : swcc_pkg::CMD_AUTO,
                      $urandom, INT_W'($urandom));
        end
    endtask

    task automatic test_empty_lists();
        send_beat(swcc_pkg::CMD_CROSS, '1, '1);
        send_beat(swcc_pkg::CMD_AUTO, '0, '0);
        send_beat(CMD_W'(5), $urandom, INT_W'($urandom));
        send_beat(CMD_W'(6), $urandom, INT_W'($urandom));
        send_beat(CMD_W'(7), $urandom, INT_W'($urandom));
    endtask

    // width 1.0: exact hits, a pair at exactly the width, far ends of the range
    task automatic test_extremes();
        send_beat(swcc_pkg::CMD_APPEND_FIRST, 32'h0000_0000, 16'hFFFF);
        send_beat(swcc_pkg::CMD_APPEND_FIRST, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(swcc_pkg::CMD_APPEND_FIRST, 32'h0000_8000, 16'h0001);
        send_beat(swcc_pkg::CMD_APPEND_SECOND, 32'h0000_0000, 16'hFFFF);
        send_beat(swcc_pkg::CMD_APPEND_SECOND, 32'hFFFF_FFFF, 16'h0000);
        send_beat(swcc_pkg::CMD_APPEND_SECOND, 32'h0001_0000, 16'hFFFF);
        send_beat(swcc_pkg::CMD_CROSS, '0, '0);
        send_beat(swcc_pkg::CMD_AUTO, '1, '1);
        send_beat(swcc_pkg::CMD_CLEAR, '1, '1);
        send_beat(swcc_pkg::CMD_CROSS, '0, '0);
    endtask

    task automatic test_zero_width();
        set_triangle_width('0);
        send_beat(swcc_pkg::CMD_APPEND_FIRST, 32'h1234_0000, 16'hFFFF);
        send_beat(swcc_pkg::CMD_APPEND_SECOND, 32'h1234_0000, 16'hFFFF);
        send_beat(swcc_pkg::CMD_CROSS, '0, '0);
        send_beat(swcc_pkg::CMD_AUTO, '0, '0);
    endtask

    task automatic test_random_phase(input logic [WIDTH_W-1:0] w);
        int start_beats;
        set_triangle_width(w);
        start_beats = command_beats;
        run_sequence(1'b1);
        while (command_beats - start_beats < PHASE_BEATS) begin
            run_sequence(1'b0);
        end
    endtask

    always @(negedge aclk) begin
        ready_cycle <= ready_cycle + 1;
        case ((ready_cycle / 211) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= (ready_cycle % 5 == 0);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge aclk) begin : check_results
        corr_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d %0b %0b",
                         $time, m_result_value, m_list_overflow, m_saturated);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_result_value !== want.value) begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, want.value, m_result_value);
                    mismatch_count++;
                end
                if (m_list_overflow !== want.overflow) begin
                    $display("%0t: list_overflow expected %0b actual %0b",
                             $time, want.overflow, m_list_overflow);
                    mismatch_count++;
                end
                if (m_saturated !== want.saturated) begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.saturated, m_saturated);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stick_weighted_cross_correlation verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_command <= swcc_pkg::CMD_CLEAR;
        s_position <= '0;
        s_intensity <= '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_lists();
        test_extremes();
        test_zero_width();
        test_random_phase(WIDTH_W'(1));
        test_random_phase('1);
        test_random_phase(WIDTH_W'($urandom_range(2, 1048574)));
        test_random_phase(WIDTH_W'($urandom_range(1, 512)));
        test_random_phase(swcc_pkg::WIDTH_RESET);

        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("stick_weighted_cross_correlation verification clean");
        end else begin
            $display("stick_weighted_cross_correlation verification failed");
        end
        $finish;
    end

endmodule
